### sv/usc_pkg.sv
package usc_pkg;

	localparam int DvdW  = 32;  // seconds input width
	localparam int DayW  = 16;  // whole days since the epoch fit in 16 bits
	localparam int UnitW = 16;  // width of the shared compare/subtract unit

	// reciprocals: multiply and shift gives the exact quotient
	localparam logic [DvdW-1:0] RecipSixty = 32'h8888_8889;  // ceil(2^37 / 60), any 32-bit value
	localparam logic [DvdW-1:0] RecipThree = 32'hAAAA_AAAB;  // ceil(2^33 / 3), any 32-bit value
	localparam logic [DvdW-1:0] RecipSeven = 32'h2492_4925;  // ceil(2^32 / 7), below 2^16 only
	localparam int ShiftSixty = 37;
	localparam int ShiftDay   = 36;  // divide by 3, then by 8
	localparam int ShiftWeek  = 32;

	localparam logic [2:0] DaysPerWeek  = 3'd7;
	localparam logic [2:0] EpochWeekday = 3'd4;

	localparam logic [11:0] EpochYear    = 12'd1970;
	localparam logic [8:0]  EpochYearMod = 9'd370;  // 1970 mod 400
	localparam logic [8:0]  LastYearMod  = 9'd399;
	localparam logic [8:0]  DaysYear     = 9'd365;
	localparam logic [8:0]  DaysLeapYear = 9'd366;
	localparam logic [3:0]  MonFeb       = 4'd1;
	localparam logic [3:0]  MonDec       = 4'd11;

	localparam logic [4:0] MonthLen [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DSEC,
		ST_DMIN,
		ST_DHOUR,
		ST_DWDAY,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;  // item in work or result waiting in the core
		logic done;  // result fields are final
	} stat_t;

	typedef struct packed {
		logic [5:0]  second_of_minute;
		logic [5:0]  minute_of_hour;
		logic [4:0]  hour_of_day;
		logic [4:0]  day_of_month;
		logic [3:0]  month_index;
		logic [11:0] year_number;
		logic [2:0]  weekday;
		logic [8:0]  day_of_year;
	} cal_t;

	// leap rule on the year mod 400
	function automatic logic is_leap(input logic [8:0] ymod);
		is_leap = (ymod[1:0] == 2'd0) &&
			!((ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300));
	endfunction

	function automatic logic [8:0] month_days(input logic [3:0] mon, input logic leap);
		logic [8:0] len;
		len = 9'(MonthLen[mon]);
		if (mon == MonFeb && leap) begin
			len = len + 9'd1;
		end
		month_days = len;
	endfunction

endpackage

### sv/usc_subcmp.sv
module usc_subcmp (
	input  logic [usc_pkg::UnitW-1:0] a,
	input  logic [usc_pkg::UnitW-1:0] b,
	output logic                      ge,
	output logic [usc_pkg::UnitW-1:0] diff
);

	logic [usc_pkg::UnitW:0] full;

	// one subtractor; the borrow gives the compare
	assign full = {1'b0, a} - {1'b0, b};
	assign ge   = ~full[usc_pkg::UnitW];
	assign diff = full[usc_pkg::UnitW-1:0];

endmodule

### sv/usc_core.sv
module usc_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [usc_pkg::DvdW-1:0] secs,
	input  logic                     ack,
	output usc_pkg::stat_t           stat,
	output usc_pkg::cal_t            res
);

	usc_pkg::state_t state_q, state_d;

	logic [usc_pkg::DvdW-1:0] dvd_q;
	logic [usc_pkg::DayW-1:0] days_q;
	logic [8:0]  ymod_q;
	logic [11:0] year_q;
	logic [3:0]  mon_q;
	logic        leap_q;
	logic [8:0]  yday_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [2:0]  wday_q;

	logic [usc_pkg::DvdW-1:0]   recip;
	logic [2*usc_pkg::DvdW-1:0] prod;
	logic [usc_pkg::DvdW-1:0]   q60;
	logic [usc_pkg::DayW-1:0]   q24;
	logic [2:0]                 q7;
	logic [5:0]                 rem60;
	logic [4:0]                 hour_nx;
	logic [2:0]                 rem7;
	logic [2:0]                 wday_nx;
	logic [usc_pkg::UnitW-1:0]  ua, ub, diff;
	logic                       ge;
	logic [8:0]                 ylen;
	logic [8:0]                 mlen;
	logic                       cur_leap;

	usc_subcmp u_subcmp (
		.a    (ua),
		.b    (ub),
		.ge   (ge),
		.diff (diff)
	);

	assign cur_leap = usc_pkg::is_leap(ymod_q);
	assign ylen     = cur_leap ? usc_pkg::DaysLeapYear : usc_pkg::DaysYear;
	assign mlen     = usc_pkg::month_days(mon_q, leap_q);

	assign ua = days_q;
	assign ub = {{(usc_pkg::UnitW-9){1'b0}}, (state_q == usc_pkg::ST_MONTH) ? mlen : ylen};

	// one 32x32 multiplier, one division per cycle
	assign recip = (state_q == usc_pkg::ST_DHOUR) ? usc_pkg::RecipThree :
		(state_q == usc_pkg::ST_DWDAY) ? usc_pkg::RecipSeven : usc_pkg::RecipSixty;
	assign prod  = 64'(dvd_q) * 64'(recip);
	assign q60   = usc_pkg::DvdW'(prod >> usc_pkg::ShiftSixty);
	assign q24   = prod[usc_pkg::ShiftDay+usc_pkg::DayW-1:usc_pkg::ShiftDay];
	assign q7    = prod[usc_pkg::ShiftWeek+2:usc_pkg::ShiftWeek];

	// remainders are small, so only low bits matter:
	// x - 60q = x + 4q mod 64, x - 24q = x + 8q mod 32, x - 7q = x + q mod 8
	assign rem60   = dvd_q[5:0] + {q60[3:0], 2'b00};
	assign hour_nx = dvd_q[4:0] + {q24[1:0], 3'b000};
	assign rem7    = dvd_q[2:0] + q7;
	assign wday_nx = (rem7 >= usc_pkg::DaysPerWeek - usc_pkg::EpochWeekday) ?
		rem7 - (usc_pkg::DaysPerWeek - usc_pkg::EpochWeekday) :
		rem7 + usc_pkg::EpochWeekday;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			usc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = usc_pkg::ST_DSEC;
				end
			end
			usc_pkg::ST_DSEC:  state_d = usc_pkg::ST_DMIN;
			usc_pkg::ST_DMIN:  state_d = usc_pkg::ST_DHOUR;
			usc_pkg::ST_DHOUR: state_d = usc_pkg::ST_DWDAY;
			usc_pkg::ST_DWDAY: state_d = usc_pkg::ST_YEAR;
			usc_pkg::ST_YEAR: begin
				if (!ge) state_d = usc_pkg::ST_MONTH;
			end
			usc_pkg::ST_MONTH: begin
				if (!ge || mon_q == usc_pkg::MonDec) state_d = usc_pkg::ST_DONE;
			end
			usc_pkg::ST_DONE: begin
				if (ack) state_d = usc_pkg::ST_IDLE;
			end
			default: state_d = usc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= usc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			usc_pkg::ST_IDLE: begin
				dvd_q <= secs;
			end
			usc_pkg::ST_DSEC: begin
				sec_q <= rem60;
				dvd_q <= q60;
			end
			usc_pkg::ST_DMIN: begin
				min_q <= rem60;
				dvd_q <= q60;
			end
			usc_pkg::ST_DHOUR: begin
				hour_q <= hour_nx;
				days_q <= q24;
				dvd_q  <= {{(usc_pkg::DvdW-usc_pkg::DayW){1'b0}}, q24};
			end
			usc_pkg::ST_DWDAY: begin
				wday_q <= wday_nx;
				year_q <= usc_pkg::EpochYear;
				ymod_q <= usc_pkg::EpochYearMod;
			end
			usc_pkg::ST_YEAR: begin
				if (ge) begin
					days_q <= diff;
					year_q <= year_q + 12'd1;
					ymod_q <= (ymod_q == usc_pkg::LastYearMod) ? 9'd0 : ymod_q + 9'd1;
				end else begin
					yday_q <= days_q[8:0];
					leap_q <= cur_leap;
					mon_q  <= '0;
				end
			end
			usc_pkg::ST_MONTH: begin
				if (ge && mon_q != usc_pkg::MonDec) begin
					days_q <= diff;
					mon_q  <= mon_q + 4'd1;
				end
			end
			usc_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != usc_pkg::ST_IDLE);
	assign stat.done = (state_q == usc_pkg::ST_DONE);

	assign res.second_of_minute = sec_q;
	assign res.minute_of_hour   = min_q;
	assign res.hour_of_day      = hour_q;
	assign res.day_of_month     = days_q[4:0] + 5'd1;
	assign res.month_index      = mon_q;
	assign res.year_number      = year_q;
	assign res.weekday          = wday_q;
	assign res.day_of_year      = yday_q;

endmodule

### sv/unix_seconds_to_calendar.sv
// Channel  Dir  Handshake              Beat payload
// secs     in   secs_valid/secs_stall  unix_seconds[31:0]
// cal      out  cal_valid/cal_stall    second, minute, hour, day, month, year,
//                                      weekday, day_of_year
//
// One beat runs reciprocal multiplication (divide by 60, 60, 24, then 7 for the
// weekday), then a subtract step for each whole year past 1970 plus a final
// compare, one for each month stepped plus a final compare, and a move into the
// output register; the conversion time is set by the year walk on the shared
// compare/subtract unit.
// arst_n clears the sequencer and the output valid; no datapath reset.
// secs_stall is high from acceptance until the result moves to the output
// register; the next beat is taken while the previous result sits unclaimed.
module unix_seconds_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        secs_valid,
	output logic        secs_stall,
	input  logic [31:0] unix_seconds,
	output logic        cal_valid,
	input  logic        cal_stall,
	output logic [5:0]  second_of_minute,
	output logic [5:0]  minute_of_hour,
	output logic [4:0]  hour_of_day,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month_index,
	output logic [11:0] year_number,
	output logic [2:0]  weekday,
	output logic [8:0]  day_of_year
);

	usc_pkg::stat_t stat;
	usc_pkg::cal_t  core_res;
	usc_pkg::cal_t  out_q;
	logic           cal_valid_q;
	logic           start;
	logic           load;

	// core only takes a beat from its idle state
	assign secs_stall = stat.busy;
	assign start      = secs_valid && !stat.busy;

	// output slot is free when empty or being drained this cycle
	assign load = stat.done && (!cal_valid_q || !cal_stall);

	usc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.secs   (unix_seconds),
		.ack    (load),
		.stat   (stat),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_valid_q <= 1'b0;
		end else if (load) begin
			cal_valid_q <= 1'b1;
		end else if (!cal_stall) begin
			cal_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= core_res;
		end
	end

	assign cal_valid        = cal_valid_q;
	assign second_of_minute = out_q.second_of_minute;
	assign minute_of_hour   = out_q.minute_of_hour;
	assign hour_of_day      = out_q.hour_of_day;
	assign day_of_month     = out_q.day_of_month;
	assign month_index      = out_q.month_index;
	assign year_number      = out_q.year_number;
	assign weekday          = out_q.weekday;
	assign day_of_year      = out_q.day_of_year;

endmodule

### sv/usc_checker.sv
module usc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        secs_valid,
	input logic        secs_stall,
	input logic        cal_valid,
	input logic        cal_stall,
	input logic [5:0]  second_of_minute,
	input logic [5:0]  minute_of_hour,
	input logic [4:0]  hour_of_day,
	input logic [4:0]  day_of_month,
	input logic [3:0]  month_index,
	input logic [11:0] year_number,
	input logic [2:0]  weekday,
	input logic [8:0]  day_of_year
);

	// an accepted beat keeps the input side busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		secs_valid && !secs_stall |=> secs_stall)
		else $error("input not stalled after accept");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> second_of_minute < 6'd60 && minute_of_hour < 6'd60 &&
			hour_of_day < 5'd24)
		else $error("time of day out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> day_of_month != 5'd0 && month_index < 4'd12 &&
			weekday < 3'd7 && day_of_year <= 9'd365 &&
			year_number >= 12'd1970 && year_number <= 12'd2106)
		else $error("date out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid && cal_stall |=> cal_valid && $stable(year_number) &&
			$stable(day_of_year) && $stable(second_of_minute))
		else $error("stalled result changed");

endmodule

bind unix_seconds_to_calendar usc_checker u_usc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.secs_valid       (secs_valid),
	.secs_stall       (secs_stall),
	.cal_valid        (cal_valid),
	.cal_stall        (cal_stall),
	.second_of_minute (second_of_minute),
	.minute_of_hour   (minute_of_hour),
	.hour_of_day      (hour_of_day),
	.day_of_month     (day_of_month),
	.month_index      (month_index),
	.year_number      (year_number),
	.weekday          (weekday),
	.day_of_year      (day_of_year)
);

### dv/calendar_check.sv
module calendar_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        secs_valid,
	input  logic        secs_stall,
	input  logic [31:0] unix_seconds,
	input  logic        cal_valid,
	input  logic        cal_stall,
	input  logic [5:0]  second_of_minute,
	input  logic [5:0]  minute_of_hour,
	input  logic [4:0]  hour_of_day,
	input  logic [4:0]  day_of_month,
	input  logic [3:0]  month_index,
	input  logic [11:0] year_number,
	input  logic [2:0]  weekday,
	input  logic [8:0]  day_of_year,
	output int          mismatches,
	output int          dates_checked,
	output int          dates_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned BaseYear    = 1970;
	localparam int unsigned BaseWeekday = 4;  // 1970-01-01 was a Thursday

	typedef struct {
		logic [31:0]   secs;
		usc_pkg::cal_t date;
	} pending_date_t;

	pending_date_t pending_dates [$];
	pending_date_t want;
	pending_date_t fresh;
	usc_pkg::cal_t seen;

	function automatic usc_pkg::cal_t to_calendar(input logic [31:0] secs);
		int unsigned   mon_len_tbl [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		int unsigned   t;
		int unsigned   days;
		int unsigned   yr;
		int unsigned   ylen;
		int unsigned   mon;
		int unsigned   mlen;
		bit            leap;
		usc_pkg::cal_t d;
		t = secs;
		d.second_of_minute = 6'(t % 60);
		t = t / 60;
		d.minute_of_hour = 6'(t % 60);
		t = t / 60;
		d.hour_of_day = 5'(t % 24);
		days = t / 24;
		d.weekday = 3'((days + BaseWeekday) % 7);
		// strip whole years, leap status tracks the current year
		yr   = BaseYear;
		leap = 1'b0;
		ylen = 365;
		while (days >= ylen) begin
			days = days - ylen;
			yr++;
			leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
			ylen = leap ? 366 : 365;
		end
		d.day_of_year = 9'(days);
		d.year_number = 12'(yr);
		// then whole months; December takes whatever is left
		mon  = 0;
		mlen = mon_len_tbl[0];
		while (mon < 11 && days >= mlen) begin
			days = days - mlen;
			mon++;
			mlen = mon_len_tbl[mon] + ((mon == 1 && leap) ? 1 : 0);
		end
		d.month_index  = 4'(mon);
		d.day_of_month = 5'(days + 1);
		return d;
	endfunction

	initial begin
		mismatches    = 0;
		dates_checked = 0;
		dates_pending = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (secs_valid && !secs_stall) begin
				fresh.secs = unix_seconds;
				fresh.date = to_calendar(unix_seconds);
				pending_dates.push_back(fresh);
			end
			if (cal_valid && !cal_stall) begin
				seen = {second_of_minute, minute_of_hour, hour_of_day, day_of_month,
					month_index, year_number, weekday, day_of_year};
				dates_checked++;
				if (pending_dates.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: date beat with nothing pending: %p", $realtime, seen);
				end else begin
					want = pending_dates.pop_front();
					if (seen !== want.date) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: secs %0d", $realtime, want.secs);
							$display("  want y %0d m %0d d %0d %0d:%0d:%0d wd %0d yd %0d",
								want.date.year_number, want.date.month_index,
								want.date.day_of_month, want.date.hour_of_day,
								want.date.minute_of_hour, want.date.second_of_minute,
								want.date.weekday, want.date.day_of_year);
							$display("  got  y %0d m %0d d %0d %0d:%0d:%0d wd %0d yd %0d",
								seen.year_number, seen.month_index, seen.day_of_month,
								seen.hour_of_day, seen.minute_of_hour,
								seen.second_of_minute, seen.weekday, seen.day_of_year);
						end
					end
				end
			end
			dates_pending = pending_dates.size();
		end
	end

endmodule

### dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandBeats   = 630;
	localparam int HoldAt      = 120;  // output beat count where the long hold-off starts
	localparam int HoldCycles  = 400;
	localparam int BurstFirst  = 300;  // beats in [BurstFirst, BurstLast) run with no gaps
	localparam int BurstLast   = 380;
	localparam int DrainCycles = 300;  // longer than the worst conversion time

	logic        clk = 1'b0;
	logic        arst_n;
	logic        secs_valid;
	logic        secs_stall;
	logic [31:0] unix_seconds;
	logic        cal_valid;
	logic        cal_stall;
	logic [5:0]  second_of_minute;
	logic [5:0]  minute_of_hour;
	logic [4:0]  hour_of_day;
	logic [4:0]  day_of_month;
	logic [3:0]  month_index;
	logic [11:0] year_number;
	logic [2:0]  weekday;
	logic [8:0]  day_of_year;

	int chk_mismatches;
	int chk_dates;
	int chk_pending;
	int beats_sent;
	int beats_taken;

	// corner inputs: epoch, unit rollovers, leap/century years, signed 32-bit rollover, top of range
	logic [31:0] corner_secs [20] = '{
		32'd0,          32'd1,          32'd59,         32'd60,
		32'd3599,       32'd3600,       32'd86399,      32'd86400,
		32'd31535999,   32'd68169600,   32'd951782400,  32'd951868800,
		32'd978220799,  32'd978307200,  32'd2147483647, 32'd2147483648,
		32'd4107542399, 32'd4260211200, 32'd4291747199, 32'hFFFF_FFFF
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	unix_seconds_to_calendar u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.secs_valid       (secs_valid),
		.secs_stall       (secs_stall),
		.unix_seconds     (unix_seconds),
		.cal_valid        (cal_valid),
		.cal_stall        (cal_stall),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.day_of_month     (day_of_month),
		.month_index      (month_index),
		.year_number      (year_number),
		.weekday          (weekday),
		.day_of_year      (day_of_year)
	);

	calendar_check u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.secs_valid       (secs_valid),
		.secs_stall       (secs_stall),
		.unix_seconds     (unix_seconds),
		.cal_valid        (cal_valid),
		.cal_stall        (cal_stall),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.day_of_month     (day_of_month),
		.month_index      (month_index),
		.year_number      (year_number),
		.weekday          (weekday),
		.day_of_year      (day_of_year),
		.mismatches       (chk_mismatches),
		.dates_checked    (chk_dates),
		.dates_pending    (chk_pending)
	);

	// One input beat. Called at a falling edge, returns at a falling edge.
	// The optional gap drops valid first; with no gap, valid stays high and
	// only the payload moves on to the next value.
	task automatic send_secs(input logic [31:0] value);
		int gap;
		gap = (beats_sent >= BurstFirst && beats_sent < BurstLast) ? 0 :
			$urandom_range(0, 15);
		if (gap > 0) begin
			secs_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		unix_seconds <= value;
		secs_valid   <= 1'b1;
		do
			@(posedge clk);
		while (secs_stall);
		beats_sent++;
		@(negedge clk);
	endtask

	// Output side: random hold per beat, no holds during the burst window,
	// and one long hold-off so the core fills and backs up the input.
	initial begin
		int hold;
		cal_stall   = 1'b0;
		beats_taken = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (beats_taken == HoldAt)
				hold = HoldCycles;
			else if (beats_taken >= BurstFirst && beats_taken < BurstLast)
				hold = 0;
			else
				hold = $urandom_range(0, 15);
			if (hold > 0) begin
				cal_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			cal_stall <= 1'b0;
			do
				@(posedge clk);
			while (!cal_valid);
			beats_taken++;
			@(negedge clk);
		end
	end

	// Main stimulus: corners first, then a mix aimed at the rollover points.
	initial begin
		logic [31:0] value;
		logic [31:0] yr_start;
		int          n;
		int unsigned y;
		arst_n       = 1'b0;
		secs_valid   = 1'b0;
		unix_seconds = '0;
		beats_sent   = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (corner_secs[i])
			send_secs(corner_secs[i]);

		for (int i = 0; i < RandBeats; i++) begin
			case ($urandom_range(0, 4))
				0, 1: value = $urandom;
				// a few seconds either side of some midnight
				2: value = ($urandom / 86400) * 86400 + $urandom_range(0, 7) - 4;
				// within a day of some New Year, leap years included
				3: begin
					yr_start = '0;
					n = $urandom_range(0, 135);
					for (int k = 0; k < n; k++) begin
						y = 1970 + k;
						yr_start += ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ?
							32'd31622400 : 32'd31536000;
					end
					value = yr_start + $urandom_range(0, 172800) - 86400;
				end
				// 2097 onward, around the 2100 non-leap century
				default: value = $urandom | 32'hF000_0000;
			endcase
			send_secs(value);
		end
		secs_valid <= 1'b0;

		// wait out every pending date, then DrainCycles quiet cycles
		// to catch any stray output beat
		do
			@(negedge clk);
		while (chk_pending != 0);
		repeat (DrainCycles) @(negedge clk);

		$display("%0d second counts sent, %0d calendar dates compared", beats_sent, chk_dates);
		$display("corners, day/year rollovers, 2100 century and a %0d-cycle output hold",
			HoldCycles);
		if (chk_mismatches == 0 && chk_pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#15_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
sv/usc_pkg.sv
sv/usc_subcmp.sv
sv/usc_core.sv
sv/unix_seconds_to_calendar.sv
sv/usc_checker.sv
dv/calendar_check.sv
dv/tb.sv
